@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("concurrent assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

@@ rtl/docc_pkg.sv @@
// ----------------------------------------------------------------------------
// docc_pkg
// shared types, constants and helpers of the output current calibrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package docc_pkg;

  localparam int unsigned SAMPLES_PER_LEVEL_DEF = 10;
  localparam int unsigned QUEUE_DEPTH_DEF       = 2;

  localparam logic [1:0] FUNC_START    = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE   = 2'd1;
  localparam logic [1:0] FUNC_READBACK = 2'd2;

  localparam int unsigned CODE_W = 6;
  localparam int unsigned ONES_W = 4;
  localparam int unsigned SMP_W  = 4;
  localparam int unsigned BITS_W = 7;
  localparam int unsigned WT_W   = 14;
  localparam int unsigned NUM_W  = 18;
  localparam int unsigned TGT_W  = 8;
  localparam int unsigned ERR_W  = 8;

  localparam logic [CODE_W-1:0] LEVEL_MAX = 6'd63;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_SAMPLE,
    CMD_READBACK,
    CMD_NONE
  } docc_cmd_e;

  typedef struct packed {
    docc_cmd_e          kind;
    logic [ONES_W-1:0]  ones;
    logic [CODE_W-1:0]  rb;
  } docc_item_t;

  function automatic logic [ONES_W-1:0] ones_in_byte(input logic [7:0] b);
    logic [ONES_W-1:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + ONES_W'(b[i]);
    end
    return n;
  endfunction

  function automatic logic [CODE_W-1:0] extract_current(input logic [31:0] v);
    return {v[15], v[23], v[31], v[14], v[22], v[30]};
  endfunction

  function automatic logic [31:0] make_mode_word(input logic [CODE_W-1:0] code,
                                                 input logic auto_mode);
    logic [CODE_W-1:0] c;
    logic [31:0]       w;
    c     = code ^ LEVEL_MAX;
    w     = 32'h0000_0046;
    w[7]  = auto_mode;
    w[30] = c[0];
    w[22] = c[1];
    w[14] = c[2];
    w[31] = c[3];
    w[23] = c[4];
    w[15] = c[5];
    return w;
  endfunction

endpackage

@@ rtl/dram_output_current_calibrator_top.sv @@
// ----------------------------------------------------------------------------
// dram_output_current_calibrator_top
// result path: front hold register, request queue, output register
// closing manual sample: target numerator, reciprocal multiply for the
// division (skipped on failure), then first auto-mode word or failure
// throughput: one transaction per cycle unless output or sweep stalls
// reset: rst_ni clears the sweep state to idle with all codes at zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dram_output_current_calibrator_top #(
  parameter int unsigned SAMPLES_PER_LEVEL = docc_pkg::SAMPLES_PER_LEVEL_DEF,
  parameter int unsigned QUEUE_DEPTH       = docc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sample_byte, readback_word
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // mode_word, current_code
  output logic [2:0]  m_axis_tuser    // apply, done_res, failed
);

  logic                 push_valid, push_ready;
  docc_pkg::docc_item_t push_item;
  logic                 q_valid, q_pop;
  docc_pkg::docc_item_t q_item;

  docc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  docc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_item_i  (push_item),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_item_o  (q_item)
  );

  docc_back #(
    .SAMPLES_PER_LEVEL (SAMPLES_PER_LEVEL)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_pop_o    (q_pop),
    .item_i        (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ rtl/docc_front.sv @@
// ----------------------------------------------------------------------------
// docc_front
// input stage: takes a transaction, decodes the request and its payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module docc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [39:0]           s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output docc_pkg::docc_item_t  push_item_o
);

  logic                 hold_valid_q, hold_valid_d;
  docc_pkg::docc_item_t hold_item_q, item_d;
  logic                 take;

  assign s_axis_tready = !hold_valid_q || push_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign push_valid_o  = hold_valid_q;
  assign push_item_o   = hold_item_q;

  always_comb begin
    item_d.ones = docc_pkg::ones_in_byte(s_axis_tdata[7:0]);
    item_d.rb   = docc_pkg::extract_current(s_axis_tdata[39:8]);
    case (s_axis_tuser)
      docc_pkg::FUNC_START:    item_d.kind = docc_pkg::CMD_START;
      docc_pkg::FUNC_SAMPLE:   item_d.kind = docc_pkg::CMD_SAMPLE;
      docc_pkg::FUNC_READBACK: item_d.kind = docc_pkg::CMD_READBACK;
      default:                 item_d.kind = docc_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (take) begin
      hold_valid_d = 1'b1;
    end else if (push_ready_i) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_item_q <= item_d;
    end
  end

endmodule

@@ rtl/docc_fifo.sv @@
// ----------------------------------------------------------------------------
// docc_fifo
// short request queue between the decode stage and the sweep engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module docc_fifo #(
  parameter int unsigned DEPTH = docc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  docc_pkg::docc_item_t  wr_item_i,
  output logic                  rd_valid_o,
  input  logic                  rd_pop_i,
  output docc_pkg::docc_item_t  rd_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  docc_pkg::docc_item_t mem_q [DEPTH];
  logic [PTR_W-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 wr_en, rd_en;

  assign wr_ready_o = (cnt_q != CNT_FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_pop_i && rd_valid_o;
  assign rd_item_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (wr_en) begin
      wp_d = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
    end
    if (rd_en) begin
      rp_d = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wp_q] <= wr_item_i;
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_FULL)
  `ASSERT_CLK(a_empty_ptr, clk_i, rst_ni, (cnt_q == '0) |-> (wp_q == rp_q))

endmodule

@@ rtl/docc_back.sv @@
// ----------------------------------------------------------------------------
// docc_back
// sweep engine: manual accuracy sweep, target division, auto code search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module docc_back #(
  parameter int unsigned SAMPLES_PER_LEVEL = docc_pkg::SAMPLES_PER_LEVEL_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_pop_o,
  input  docc_pkg::docc_item_t  item_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,
  output logic [2:0]            m_axis_tuser
);

  localparam int unsigned CODE_W = docc_pkg::CODE_W;
  localparam int unsigned BITS_W = docc_pkg::BITS_W;
  localparam int unsigned WT_W   = docc_pkg::WT_W;
  localparam int unsigned NUM_W  = docc_pkg::NUM_W;
  localparam int unsigned TGT_W  = docc_pkg::TGT_W;
  localparam int unsigned ERR_W  = docc_pkg::ERR_W;
  localparam int unsigned SMP_W  = docc_pkg::SMP_W;
  localparam int unsigned RCP_SH = 27;
  localparam int unsigned RCP_W  = 22;

  localparam logic [SMP_W-1:0]  SPL       = SMP_W'(SAMPLES_PER_LEVEL);
  localparam logic [BITS_W-1:0] FULL      = BITS_W'(8 * SAMPLES_PER_LEVEL);
  localparam logic [NUM_W-1:0]  BIAS      = NUM_W'(20 * SAMPLES_PER_LEVEL);
  localparam logic [NUM_W-1:0]  DEN       = NUM_W'(40 * SAMPLES_PER_LEVEL);
  // ceil(2^RCP_SH / den), exact for every numerator the sweep can produce
  localparam logic [RCP_W-1:0]  RCP       =
    RCP_W'(((1 << RCP_SH) + 40 * SAMPLES_PER_LEVEL - 1) / (40 * SAMPLES_PER_LEVEL));

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_MANUAL = 2'd1;
  localparam logic [1:0] PH_AUTO   = 2'd2;

  localparam logic [1:0] BK_RUN = 2'd0;
  localparam logic [1:0] BK_NUM = 2'd1;
  localparam logic [1:0] BK_DIV = 2'd2;
  localparam logic [1:0] BK_FIN = 2'd3;

  logic [1:0]              st_q, st_d;
  logic [1:0]              phase_q, phase_d;
  logic [CODE_W-1:0]       level_q, level_d;
  logic [SMP_W-1:0]        smp_q, smp_d;
  logic [BITS_W-1:0]       lb_q, lb_d;
  logic [BITS_W-1:0]       prev_q, prev_d;
  logic signed [WT_W-1:0]  wt_q, wt_d;
  logic [TGT_W-1:0]        tgt_q, tgt_d;
  logic [ERR_W-1:0]        lerr_q, lerr_d;
  logic [CODE_W-1:0]       best_q, best_d;
  logic                    fail_q, fail_d;
  logic [NUM_W-1:0]        num_q, num_d;
  logic [TGT_W-1:0]        quo_q, quo_d;

  logic                    out_valid_q;
  logic [31:0]             out_word_q, res_word;
  logic [CODE_W-1:0]       out_code_q, res_code;
  logic                    out_apply_q, res_apply;
  logic                    out_done_q, res_done;
  logic                    out_fail_q, res_fail;
  logic                    out_free, load;

  logic [BITS_W-1:0]       lb_new;
  logic [SMP_W-1:0]        smp_new;
  logic signed [BITS_W:0]  bits_diff;
  logic signed [WT_W-1:0]  prod;
  logic signed [WT_W-1:0]  wt_new;
  logic [CODE_W-1:0]       level_inc;
  logic signed [NUM_W-1:0] wt_ext, num;
  logic [NUM_W+RCP_W-1:0]  quo_full;
  logic signed [TGT_W+1:0] rb_diff;
  logic [ERR_W-1:0]        err;
  logic                    upd;
  logic [CODE_W-1:0]       best_new;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_code_q, out_word_q};
  assign m_axis_tuser  = {out_fail_q, out_done_q, out_apply_q};

  always_comb begin
    lb_new    = lb_q + BITS_W'(item_i.ones);
    smp_new   = smp_q + 1'b1;
    bits_diff = $signed({1'b0, lb_new}) - $signed({1'b0, prev_q});
    prod      = WT_W'(bits_diff) * WT_W'($signed({1'b0, level_q}));
    wt_new    = wt_q + prod;
    level_inc = level_q + 1'b1;
    wt_ext    = NUM_W'(wt_q);
    num       = (wt_ext <<< 3) + (wt_ext <<< 1) + wt_ext + $signed(BIAS);
    quo_full  = num_q * RCP;
    rb_diff   = $signed({2'b00, TGT_W'(item_i.rb)}) - $signed({2'b00, tgt_q});
    err       = rb_diff[TGT_W+1] ? ERR_W'(-rb_diff) : ERR_W'(rb_diff);
    upd       = (level_q == '0) || (err < lerr_q);
    best_new  = upd ? level_q : best_q;
  end

  always_comb begin
    st_d      = st_q;
    phase_d   = phase_q;
    level_d   = level_q;
    smp_d     = smp_q;
    lb_d      = lb_q;
    prev_d    = prev_q;
    wt_d      = wt_q;
    tgt_d     = tgt_q;
    lerr_d    = lerr_q;
    best_d    = best_q;
    fail_d    = fail_q;
    num_d     = num_q;
    quo_d     = quo_q;
    item_pop_o = 1'b0;
    load      = 1'b0;
    res_word  = '0;
    res_apply = 1'b0;
    res_done  = 1'b0;
    res_fail  = 1'b0;
    res_code  = level_q;
    case (st_q)
      BK_RUN: begin
        if (item_valid_i && out_free) begin
          item_pop_o = 1'b1;
          load       = 1'b1;
          case (item_i.kind)
            docc_pkg::CMD_START: begin
              phase_d   = PH_MANUAL;
              level_d   = '0;
              smp_d     = '0;
              lb_d      = '0;
              prev_d    = '0;
              wt_d      = '0;
              tgt_d     = '0;
              lerr_d    = '0;
              best_d    = '0;
              res_word  = docc_pkg::make_mode_word('0, 1'b0);
              res_apply = 1'b1;
              res_code  = '0;
            end
            docc_pkg::CMD_SAMPLE: begin
              if (phase_q == PH_MANUAL) begin
                lb_d  = lb_new;
                smp_d = smp_new;
                if (smp_new < SPL) begin
                  res_word = docc_pkg::make_mode_word(level_q, 1'b0);
                end else begin
                  wt_d  = wt_new;
                  smp_d = '0;
                  lb_d  = '0;
                  if (lb_new < FULL && level_q != docc_pkg::LEVEL_MAX) begin
                    prev_d    = lb_new;
                    level_d   = level_inc;
                    res_word  = docc_pkg::make_mode_word(level_inc, 1'b0);
                    res_apply = 1'b1;
                    res_code  = level_inc;
                  end else begin
                    level_d = '0;
                    load    = 1'b0;
                    st_d    = BK_NUM;
                  end
                end
              end
            end
            docc_pkg::CMD_READBACK: begin
              if (phase_q == PH_AUTO) begin
                lerr_d    = upd ? err : lerr_q;
                best_d    = best_new;
                res_apply = 1'b1;
                if (TGT_W'(item_i.rb) > tgt_q || level_q == docc_pkg::LEVEL_MAX) begin
                  phase_d  = PH_IDLE;
                  res_word = docc_pkg::make_mode_word(best_new, 1'b1);
                  res_done = 1'b1;
                  res_code = best_new;
                end else begin
                  level_d  = level_inc;
                  res_word = docc_pkg::make_mode_word(level_inc, 1'b1);
                  res_code = level_inc;
                end
              end
            end
            default: begin
              res_code = level_q;
            end
          endcase
        end
      end
      BK_NUM: begin
        fail_d = (num < $signed(DEN));
        num_d  = num;
        st_d   = (num < $signed(DEN)) ? BK_FIN : BK_DIV;
      end
      BK_DIV: begin
        // reciprocal multiply stands in for the division by den
        quo_d = quo_full[RCP_SH +: TGT_W];
        st_d  = BK_FIN;
      end
      BK_FIN: begin
        if (out_free) begin
          load = 1'b1;
          st_d = BK_RUN;
          if (fail_q) begin
            tgt_d    = '0;
            phase_d  = PH_IDLE;
            res_done = 1'b1;
            res_fail = 1'b1;
            res_code = '0;
          end else begin
            tgt_d     = quo_q;
            lerr_d    = '0;
            best_d    = '0;
            phase_d   = PH_AUTO;
            res_word  = docc_pkg::make_mode_word('0, 1'b1);
            res_apply = 1'b1;
            res_code  = '0;
          end
        end
      end
      default: begin
        st_d = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_RUN;
      phase_q     <= PH_IDLE;
      level_q     <= '0;
      smp_q       <= '0;
      lb_q        <= '0;
      prev_q      <= '0;
      wt_q        <= '0;
      tgt_q       <= '0;
      lerr_q      <= '0;
      best_q      <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      phase_q <= phase_d;
      level_q <= level_d;
      smp_q   <= smp_d;
      lb_q    <= lb_d;
      prev_q  <= prev_d;
      wt_q    <= wt_d;
      tgt_q   <= tgt_d;
      lerr_q  <= lerr_d;
      best_q  <= best_d;
      fail_q  <= fail_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    if (load) begin
      out_word_q  <= res_word;
      out_code_q  <= res_code;
      out_apply_q <= res_apply;
      out_done_q  <= res_done;
      out_fail_q  <= res_fail;
    end
  end

  `ASSERT_CLK(a_div_manual, clk_i, rst_ni, (st_q != BK_RUN) |-> (phase_q == PH_MANUAL))
  `ASSERT_NEVER(a_pop_busy, clk_i, rst_ni, item_pop_o && (st_q != BK_RUN))
  `ASSERT_CLK(a_done_idle, clk_i, rst_ni, (load && res_done) |=> (phase_q == PH_IDLE))

endmodule
